@@ rtl/mbhc_pkg.sv @@
// Shared types and constants for the mesh bilinear height correction block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mbhc_pkg;

	localparam int POS_W      = 21;
	localparam int SP_W       = 20;
	localparam int H_W        = 16;
	localparam int IDX_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;
	localparam int BASE_W     = 27;
	localparam int OPB_W      = 28;
	localparam int OPA_W      = 48;
	localparam int CHUNK_W    = 16;
	localparam int PROD_W     = CHUNK_W + 1 + OPB_W;
	localparam int ACC_W      = 64;
	localparam int DEN_W      = 40;
	localparam int DIV_STEPS  = ACC_W;
	localparam int CNT_W      = 6;

	localparam logic signed [H_W-1:0] UNDEF_HEIGHT = 16'sh7FFF;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAISE_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAISE_VALUE  = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_READ,
		ST_RWAIT,
		ST_UNDCHK,
		ST_MUL,
		ST_DRAIN,
		ST_SAVE,
		ST_DIVINIT,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_OFF,
		KIND_UNDEF,
		KIND_VALUE
	} kind_t;

	typedef enum logic [1:0] {
		SAVE_L0,
		SAVE_L1,
		SAVE_DEN,
		SAVE_NONE
	} save_t;

	// Products formed by the shared multiply-accumulate unit, in issue order.
	typedef enum logic [2:0] {
		P_Z00_AX,
		P_Z10_DX,
		P_Z01_AX,
		P_Z11_DX,
		P_SX_SY,
		P_L0_AY,
		P_L1_DY
	} mul_t;

	typedef struct packed {
		logic       load_item;
		logic       search_step;
		logic       prep;
		logic       rd_req;
		logic [1:0] rd_corner;
		logic       mac_go;
		mul_t       mac_sel;
		logic [1:0] mac_chunk;
		logic       acc_clr;
		save_t      save_sel;
		logic       div_init;
		logic       div_step;
		logic       out_load;
		kind_t      out_kind;
	} cmd_t;

	typedef struct packed {
		logic off_hit;
		logic undef_hit;
	} stat_t;

endpackage

@@ rtl/mbhc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used by the datapath for the grid heights.
module mbhc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/mbhc_ctrl.sv @@
// Controller state machine: sequences cell search, corner reads, the multiply
// schedule and the divider. Depends on mbhc_pkg; drives the datapath by cmd_t.
module mbhc_ctrl #(
	parameter int GRID_COLS = 16,
	parameter int GRID_ROWS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            action,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  mbhc_pkg::stat_t stat,
	output mbhc_pkg::cmd_t  cmd
);
	import mbhc_pkg::*;

	localparam int SRCH_N   = ((GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS) - 2;
	localparam int SRCH_CYC = (SRCH_N > 0) ? SRCH_N : 1;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	mul_t             p_q;
	save_t            save_q;
	kind_t            kind_q;
	logic             out_valid_q;
	logic             accept;
	logic             fin_go;
	logic             group_end;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign fin_go    = !out_valid_q || out_ready;
	assign group_end = (p_q == P_Z10_DX) || (p_q == P_Z11_DX) || (p_q == P_SX_SY)
		|| (p_q == P_L1_DY);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = action ? ST_CHECK : ST_FIN;
				end
			end
			ST_CHECK:   state_d = stat.off_hit ? ST_FIN : ST_SEARCH;
			ST_SEARCH: begin
				if (cnt_q == CNT_W'(SRCH_CYC - 1)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (cnt_q == CNT_W'(3)) begin
					state_d = ST_RWAIT;
				end
			end
			ST_RWAIT:   state_d = ST_UNDCHK;
			ST_UNDCHK:  state_d = stat.undef_hit ? ST_FIN : ST_MUL;
			ST_MUL: begin
				if (cnt_q == CNT_W'(2) && group_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:   state_d = (save_q == SAVE_NONE) ? ST_DIVINIT : ST_SAVE;
			ST_SAVE:    state_d = ST_MUL;
			ST_DIVINIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.save_sel = SAVE_NONE;
		cmd.out_kind = kind_q;
		cmd.mac_sel  = p_q;
		unique case (state_q)
			ST_IDLE:    cmd.load_item = accept;
			ST_SEARCH:  cmd.search_step = 1'b1;
			ST_READ: begin
				cmd.prep      = 1'b1;
				cmd.rd_req    = 1'b1;
				cmd.rd_corner = cnt_q[1:0];
			end
			ST_UNDCHK:  cmd.acc_clr = 1'b1;
			ST_MUL: begin
				cmd.mac_go    = 1'b1;
				cmd.mac_chunk = cnt_q[1:0];
			end
			ST_SAVE: begin
				cmd.save_sel = save_q;
				cmd.acc_clr  = 1'b1;
			end
			ST_DIVINIT: cmd.div_init = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_FIN:     cmd.out_load = fin_go;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			p_q         <= P_Z00_AX;
			save_q      <= SAVE_NONE;
			kind_q      <= KIND_WRITE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// The chunk counter also restarts after each product in the multiply phase.
			if (state_q != state_d || (state_q == ST_MUL && cnt_q == CNT_W'(2))) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE:   kind_q <= action ? KIND_VALUE : KIND_WRITE;
				ST_CHECK:  kind_q <= stat.off_hit ? KIND_OFF : KIND_VALUE;
				ST_UNDCHK: begin
					kind_q <= stat.undef_hit ? KIND_UNDEF : KIND_VALUE;
					p_q    <= P_Z00_AX;
				end
				ST_MUL: begin
					if (cnt_q == CNT_W'(2)) begin
						if (p_q != P_L1_DY) begin
							p_q <= mul_t'(p_q + 3'd1);
						end
						case (p_q)
							P_Z10_DX: save_q <= SAVE_L0;
							P_Z11_DX: save_q <= SAVE_L1;
							P_SX_SY:  save_q <= SAVE_DEN;
							P_L1_DY:  save_q <= SAVE_NONE;
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/mbhc_dp.sv @@
// Datapath: configuration registers, grid store, cell search, shared
// multiply-accumulate, restoring divider and result register. Uses mbhc_pkg, mbhc_ram.
module mbhc_dp #(
	parameter int GRID_COLS = 16,
	parameter int GRID_ROWS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mbhc_pkg::cmd_t                        cmd,
	output mbhc_pkg::stat_t                       stat,
	input  logic                                  action,
	input  logic [mbhc_pkg::IDX_W-1:0]            col_index,
	input  logic [mbhc_pkg::IDX_W-1:0]            row_index,
	input  logic signed [mbhc_pkg::H_W-1:0]       point_height,
	input  logic signed [mbhc_pkg::POS_W-1:0]     pos_x,
	input  logic signed [mbhc_pkg::POS_W-1:0]     pos_y,
	input  logic                                  cfg_we,
	input  logic [mbhc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mbhc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic signed [mbhc_pkg::H_W-1:0]       correction,
	output logic                                  undefined_seen,
	output logic                                  off_mesh
);
	import mbhc_pkg::*;

	localparam int CW    = $clog2(GRID_COLS);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;

	// Configuration registers.
	logic signed [POS_W-1:0] origin_x_q, origin_y_q;
	logic [SP_W-1:0]         spacing_x_q, spacing_y_q;
	logic                    raise_enable_q;
	logic signed [H_W-1:0]   raise_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			spacing_x_q    <= SP_W'(10000);
			spacing_y_q    <= SP_W'(10000);
			raise_enable_q <= 1'b0;
			raise_value_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:     origin_x_q     <= cfg_data[POS_W-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= cfg_data[POS_W-1:0];
				REG_SPACING_X:    spacing_x_q    <= cfg_data[SP_W-1:0];
				REG_SPACING_Y:    spacing_y_q    <= cfg_data[SP_W-1:0];
				REG_RAISE_ENABLE: raise_enable_q <= cfg_data[0];
				REG_RAISE_VALUE:  raise_value_q  <= cfg_data[H_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero spacing behaves as a spacing of one.
	logic [SP_W-1:0] sx_eff, sy_eff;
	assign sx_eff = (spacing_x_q == '0) ? SP_W'(1) : spacing_x_q;
	assign sy_eff = (spacing_y_q == '0) ? SP_W'(1) : spacing_y_q;

	logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
	logic signed [BASE_W-1:0] px_e, py_e, ox_e, oy_e, sx_e, sy_e;
	logic [BASE_W-1:0]        span_x, span_y;
	logic signed [BASE_W-1:0] max_x, max_y;

	assign px_e   = {{(BASE_W-POS_W){pos_x_q[POS_W-1]}}, pos_x_q};
	assign py_e   = {{(BASE_W-POS_W){pos_y_q[POS_W-1]}}, pos_y_q};
	assign ox_e   = {{(BASE_W-POS_W){origin_x_q[POS_W-1]}}, origin_x_q};
	assign oy_e   = {{(BASE_W-POS_W){origin_y_q[POS_W-1]}}, origin_y_q};
	assign sx_e   = {{(BASE_W-SP_W){1'b0}}, sx_eff};
	assign sy_e   = {{(BASE_W-SP_W){1'b0}}, sy_eff};
	assign span_x = BASE_W'(GRID_COLS - 1) * BASE_W'(sx_eff);
	assign span_y = BASE_W'(GRID_ROWS - 1) * BASE_W'(sy_eff);
	assign max_x  = ox_e + $signed(span_x);
	assign max_y  = oy_e + $signed(span_y);

	assign stat.off_hit = raise_enable_q
		&& (px_e < ox_e || px_e > max_x || py_e < oy_e || py_e > max_y);

	// Cell search: walk the lower cell edge up one spacing per cycle.
	localparam logic [CW-1:0] CX_LAST = CW'(GRID_COLS - 2);
	localparam logic [RW-1:0] CY_LAST = RW'(GRID_ROWS - 2);

	logic signed [BASE_W-1:0] base_x_q, base_y_q, next_x, next_y;
	logic [CW-1:0]            cx_q;
	logic [RW-1:0]            cy_q;

	assign next_x = base_x_q + sx_e;
	assign next_y = base_y_q + sy_e;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			pos_x_q  <= pos_x;
			pos_y_q  <= pos_y;
			base_x_q <= ox_e;
			base_y_q <= oy_e;
			cx_q     <= '0;
			cy_q     <= '0;
		end else if (cmd.search_step) begin
			if (cx_q != CX_LAST && px_e >= next_x) begin
				base_x_q <= next_x;
				cx_q     <= cx_q + CW'(1);
			end
			if (cy_q != CY_LAST && py_e >= next_y) begin
				base_y_q <= next_y;
				cy_q     <= cy_q + RW'(1);
			end
		end
	end

	// Offsets inside the cell and their complements.
	logic signed [BASE_W-1:0] dx_c, dy_c;
	logic signed [OPB_W-1:0]  dx_q, dy_q, ax_q, ay_q;
	logic signed [OPB_W-1:0]  dx_w, dy_w, sx_w, sy_w;

	assign dx_c = px_e - base_x_q;
	assign dy_c = py_e - base_y_q;
	assign dx_w = {{(OPB_W-BASE_W){dx_c[BASE_W-1]}}, dx_c};
	assign dy_w = {{(OPB_W-BASE_W){dy_c[BASE_W-1]}}, dy_c};
	assign sx_w = {{(OPB_W-SP_W){1'b0}}, sx_eff};
	assign sy_w = {{(OPB_W-SP_W){1'b0}}, sy_eff};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			dx_q <= dx_w;
			dy_q <= dy_w;
			ax_q <= sx_w - dx_w;
			ay_q <= sy_w - dy_w;
		end
	end

	// Grid store; entries never written read as zero through the valid bits.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [H_W-1:0]   ram_rdata;
	logic [DEPTH-1:0] valid_q;
	logic             rd_vld_s1, rd_req_s1;
	logic [1:0]       rd_corner_s1;
	logic [CW-1:0]    rd_col;
	logic [RW-1:0]    rd_row;
	logic signed [H_W-1:0] z_q [4];

	assign ram_we = cmd.load_item && !action
		&& ({1'b0, col_index} < (IDX_W + 1)'(GRID_COLS))
		&& ({1'b0, row_index} < (IDX_W + 1)'(GRID_ROWS));
	assign ram_waddr = {row_index[RW-1:0], col_index[CW-1:0]};
	assign rd_col    = cx_q + CW'(cmd.rd_corner[0]);
	assign rd_row    = cy_q + RW'(cmd.rd_corner[1]);
	assign ram_raddr = {rd_row, rd_col};

	mbhc_ram #(
		.WIDTH (H_W),
		.DEPTH (DEPTH)
	) u_heights (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (point_height),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_req_s1 <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			rd_req_s1 <= cmd.rd_req;
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1    <= valid_q[ram_raddr];
		rd_corner_s1 <= cmd.rd_corner;
		if (rd_req_s1) begin
			z_q[rd_corner_s1] <= rd_vld_s1 ? $signed(ram_rdata) : '0;
		end
	end

	assign stat.undef_hit = (z_q[0] == UNDEF_HEIGHT) || (z_q[1] == UNDEF_HEIGHT)
		|| (z_q[2] == UNDEF_HEIGHT) || (z_q[3] == UNDEF_HEIGHT);

	// Shared multiply-accumulate: a 48-bit operand is taken in 16-bit chunks,
	// the top chunk signed, so the 64-bit sum wraps exactly like the
	// full-width product.
	logic signed [OPA_W-1:0]   opa;
	logic signed [OPB_W-1:0]   opb;
	logic signed [CHUNK_W:0]   chk;
	logic signed [PROD_W-1:0]  prod_c, prod_s1;
	logic [1:0]                k_s1;
	logic                      pv_s1;
	logic [ACC_W-1:0]          acc_q, addend, prod_ext;
	logic signed [OPA_W-1:0]   l0_q, l1_q;
	logic [DEN_W-1:0]          den_q;

	always_comb begin
		case (cmd.mac_sel)
			P_Z00_AX: begin
				opa = {{(OPA_W-H_W){z_q[0][H_W-1]}}, z_q[0]};
				opb = ax_q;
			end
			P_Z10_DX: begin
				opa = {{(OPA_W-H_W){z_q[1][H_W-1]}}, z_q[1]};
				opb = dx_q;
			end
			P_Z01_AX: begin
				opa = {{(OPA_W-H_W){z_q[2][H_W-1]}}, z_q[2]};
				opb = ax_q;
			end
			P_Z11_DX: begin
				opa = {{(OPA_W-H_W){z_q[3][H_W-1]}}, z_q[3]};
				opb = dx_q;
			end
			P_SX_SY: begin
				opa = {{(OPA_W-SP_W){1'b0}}, sx_eff};
				opb = sy_w;
			end
			P_L0_AY: begin
				opa = l0_q;
				opb = ay_q;
			end
			P_L1_DY: begin
				opa = l1_q;
				opb = dy_q;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		case (cmd.mac_chunk)
			2'd0:    chk = {1'b0, opa[CHUNK_W-1:0]};
			2'd1:    chk = {1'b0, opa[2*CHUNK_W-1:CHUNK_W]};
			2'd2:    chk = {opa[OPA_W-1], opa[OPA_W-1:2*CHUNK_W]};
			default: chk = '0;
		endcase
		prod_c = chk * opb;
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	always_comb begin
		case (k_s1)
			2'd0:    addend = prod_ext;
			2'd1:    addend = prod_ext << CHUNK_W;
			2'd2:    addend = prod_ext << (2 * CHUNK_W);
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mac_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		k_s1    <= cmd.mac_chunk;
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + addend;
		end
		case (cmd.save_sel)
			SAVE_L0:  l0_q  <= acc_q[OPA_W-1:0];
			SAVE_L1:  l1_q  <= acc_q[OPA_W-1:0];
			SAVE_DEN: den_q <= acc_q[DEN_W-1:0];
			default: begin
			end
		endcase
	end

	// Restoring divider for (|num| + den/2) / den, one quotient bit a cycle.
	logic [ACC_W-1:0] quo_q, half_den;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial, trial_sub;
	logic             neg_q, ge;

	assign half_den  = {{(ACC_W-DEN_W+1){1'b0}}, den_q[DEN_W-1:1]};
	assign trial     = {rem_q, quo_q[ACC_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= acc_q[ACC_W-1];
			rem_q <= '0;
			quo_q <= (acc_q ^ {ACC_W{acc_q[ACC_W-1]}}) + half_den
				+ ACC_W'(acc_q[ACC_W-1]);
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], ge};
		end
	end

	// Result register with rounding already done; saturate to 16 bits.
	logic           pos_big, neg_big;
	logic [H_W-1:0] neg_q16;

	assign pos_big = |quo_q[ACC_W-1:H_W-1];
	assign neg_big = (|quo_q[ACC_W-1:H_W]) || (quo_q[H_W-1] && (|quo_q[H_W-2:0]));
	assign neg_q16 = H_W'(0) - quo_q[H_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				KIND_OFF: begin
					correction     <= raise_value_q;
					undefined_seen <= 1'b0;
					off_mesh       <= 1'b1;
				end
				KIND_UNDEF: begin
					correction     <= '0;
					undefined_seen <= 1'b1;
					off_mesh       <= 1'b0;
				end
				KIND_VALUE: begin
					if (neg_q) begin
						correction <= neg_big ? 16'sh8000 : $signed(neg_q16);
					end else begin
						correction <= pos_big ? 16'sh7FFF : $signed(quo_q[H_W-1:0]);
					end
					undefined_seen <= 1'b0;
					off_mesh       <= 1'b0;
				end
				default: begin
					correction     <= '0;
					undefined_seen <= 1'b0;
					off_mesh       <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ rtl/mesh_bilinear_height_correction.sv @@
// Top level of the mesh bilinear height correction block.
// Joins mbhc_ctrl and mbhc_dp; depends on mbhc_pkg.
//
// Usage: the input channel (in_valid/in_ready) takes one request at a time.
// action 0 writes point_height at (col_index, row_index); action 1 queries the
// correction at (pos_x, pos_y). Each request yields exactly one result on the
// output channel (out_valid/out_ready). Registers are written through the
// cfg channel (cfg_index, cfg_data), which is always ready; write only while
// no request is in flight.
// A query works in steps: the cell search steps one grid spacing per cycle,
// the four corners come from one RAM read port, the multiply-accumulate
// unit forms seven products in three chunks each, and the restoring
// divider produces one quotient bit per cycle. An off-mesh query with the
// raise enabled, or one that meets an undefined corner, finishes early. A new
// request is taken as soon as the previous result sits in the output
// register, even if the receiver stalls it there.
// Reset clears the grid to zero and loads the register reset values.
module mesh_bilinear_height_correction #(
	parameter int GRID_COLS = 16,
	parameter int GRID_ROWS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [mbhc_pkg::IDX_W-1:0]            col_index,
	input  logic [mbhc_pkg::IDX_W-1:0]            row_index,
	input  logic signed [mbhc_pkg::H_W-1:0]       point_height,
	input  logic signed [mbhc_pkg::POS_W-1:0]     pos_x,
	input  logic signed [mbhc_pkg::POS_W-1:0]     pos_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mbhc_pkg::H_W-1:0]       correction,
	output logic                                  undefined_seen,
	output logic                                  off_mesh,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mbhc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mbhc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mbhc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	mbhc_ctrl #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mbhc_dp #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.col_index      (col_index),
		.row_index      (row_index),
		.point_height   (point_height),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.correction     (correction),
		.undefined_seen (undefined_seen),
		.off_mesh       (off_mesh)
	);

endmodule
